// ===== hw/rtl/crcls_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_pkg
// shared types and codes of the capture repeat classifier
// ----------------------------------------------------------------------------
package crcls_pkg;

	// result codes
	localparam logic [1:0] CLS_FIXED        = 2'd0;
	localparam logic [1:0] CLS_ROLLING      = 2'd1;
	localparam logic [1:0] CLS_INCONSISTENT = 2'd2;

	localparam int BYTE_W = 8;
	localparam int DIST_W = 8;

	// control of the distance accumulator
	typedef struct packed {
		logic clr;  // start a new pair
		logic vld;  // read data of both frames valid this cycle
	} acc_ctl_t;

endpackage : crcls_pkg
`default_nettype wire

// ===== hw/rtl/capture_repeat_classifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// capture_repeat_classifier_top
// collects a session of radio frames and classifies them as fixed, rolling
// or inconsistent by pairwise comparison
// ----------------------------------------------------------------------------
// throughput: one input item per cycle while frames are being captured
// comparison: after the last byte of the last frame each equal-length pair is
//   read one byte pair per cycle through the two read ports of the frame
//   store; an unequal-length pair is settled from the lengths alone; only the
//   length of b is read anew unless frame a moves on; the emit step ends it
// input is held off (s_tready low) while the pairs are being compared and the result is emitted
// reset: session counters and the output clear at once, max_bit_diff is 1;
//   frame and length stores need no clearing and are not touched
// ----------------------------------------------------------------------------
module capture_repeat_classifier_top #(
	parameter int FRAMES_PER_SESSION = 8,
	parameter int MAX_FRAME_BYTES    = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire [7:0]  cfg_wdata,   // max_bit_diff
	// input items
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,     // [7:0] data_byte
	input  wire        s_tlast,     // end_of_frame
	input  wire        s_tuser,     // abort
	// result items
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata      // [1:0] code_class, [5:2] frames_used, [7:6] zero
);
	import crcls_pkg::*;

	localparam int DEPTH  = FRAMES_PER_SESSION * MAX_FRAME_BYTES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FRM_W  = $clog2(FRAMES_PER_SESSION);
	localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);

	localparam logic [ADDR_W-1:0] STEP      = ADDR_W'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0]  POS_FULL  = POS_W'(MAX_FRAME_BYTES);
	localparam logic [FRM_W-1:0]  LAST_FRM  = FRM_W'(FRAMES_PER_SESSION - 1);
	localparam logic [FRM_W-1:0]  LAST_A    = FRM_W'(FRAMES_PER_SESSION - 2);
	localparam logic [3:0]        FRAMES_USED = 4'(FRAMES_PER_SESSION);

	// sequencer states
	localparam logic [3:0] S_CAPTURE  = 4'd0;
	localparam logic [3:0] S_LEN_A    = 4'd1;  // read length of frame a
	localparam logic [3:0] S_LEN_AW   = 4'd2;  // latch length a, read length b
	localparam logic [3:0] S_LEN_B    = 4'd3;  // read length of frame b
	localparam logic [3:0] S_CMP_INIT = 4'd4;  // compare lengths
	localparam logic [3:0] S_BYTES    = 4'd5;  // issue byte reads
	localparam logic [3:0] S_DRAIN    = 4'd6;  // last byte pair in flight
	localparam logic [3:0] S_DECIDE   = 4'd7;  // distance against tolerance
	localparam logic [3:0] S_EMIT     = 4'd8;  // hand result to output register

	logic [3:0]        state_q;
	logic [7:0]        max_bit_diff_q;

	// capture side
	logic [FRM_W-1:0]  fcnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              ovl_q;
	logic [ADDR_W-1:0] frame_base_q;

	// comparison side
	logic [FRM_W-1:0]  idx_a_q;
	logic [FRM_W-1:0]  idx_b_q;
	logic [ADDR_W-1:0] base_a_q;
	logic [ADDR_W-1:0] base_b_q;
	logic [ADDR_W-1:0] addr_a_q;
	logic [ADDR_W-1:0] addr_b_q;
	logic [POS_W-1:0]  len_a_q;
	logic [POS_W-1:0]  k_q;
	logic              rd_vld_s1;
	logic              any_match_q;
	logic              any_mismatch_q;

	// output register
	logic              out_vld_q;
	logic [1:0]        out_cls_q;

	// store connections
	logic              acc;
	logic              pos_full;
	logic              ovl_now;
	logic [POS_W-1:0]  pos_inc;
	logic              store_we;
	logic [ADDR_W-1:0] store_waddr;
	logic [BYTE_W-1:0] byte_a;
	logic [BYTE_W-1:0] byte_b;
	logic              len_we;
	logic [FRM_W-1:0]  len_raddr;
	logic [POS_W-1:0]  len_rdata;
	logic [DIST_W-1:0] pair_dist;
	logic              frame_done;
	logic              session_done;
	logic              last_byte;
	logic              pairs_done;
	logic              b_wrap;
	acc_ctl_t          acc_ctl;

	assign s_tready = (state_q == S_CAPTURE);
	assign acc      = s_tvalid && s_tready;

	// a byte beyond the frame limit marks the frame as overlong
	assign pos_full     = (pos_q == POS_FULL);
	assign ovl_now      = ovl_q || pos_full;
	assign pos_inc      = pos_q + 1'b1;
	assign store_we     = acc && !s_tuser && !pos_full;
	assign store_waddr  = frame_base_q + ADDR_W'(pos_q);
	assign frame_done   = acc && !s_tuser && s_tlast && !ovl_now;
	assign len_we       = frame_done;
	assign session_done = frame_done && (fcnt_q == LAST_FRM);

	assign len_raddr  = (state_q == S_LEN_A) ? idx_a_q : idx_b_q;
	assign last_byte  = ((k_q + 1'b1) == len_a_q);
	assign b_wrap     = (idx_b_q == LAST_FRM);
	assign pairs_done = b_wrap && (idx_a_q == LAST_A);

	assign acc_ctl.clr = (state_q == S_CMP_INIT);
	assign acc_ctl.vld = rd_vld_s1;

	crcls_frame_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_frame_store (
		.clk     (clk),
		.we      (store_we),
		.waddr   (store_waddr),
		.wdata   (s_tdata),
		.raddr_a (addr_a_q),
		.raddr_b (addr_b_q),
		.rdata_a (byte_a),
		.rdata_b (byte_b)
	);

	crcls_len_store #(
		.DEPTH (FRAMES_PER_SESSION),
		.IDX_W (FRM_W),
		.LEN_W (POS_W)
	) u_len_store (
		.clk   (clk),
		.we    (len_we),
		.waddr (fcnt_q),
		.wdata (pos_inc),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	crcls_dist_acc u_dist_acc (
		.clk    (clk),
		.ctl    (acc_ctl),
		.byte_a (byte_a),
		.byte_b (byte_b),
		.dist_q (pair_dist)
	);

	// tolerance register; the user writes it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bit_diff_q <= 8'd1;
		end else if (cfg_we) begin
			max_bit_diff_q <= cfg_wdata;
		end
	end

	// byte read pointers step through the pair, read data is valid in the next cycle
	always_ff @(posedge clk) begin
		if (state_q == S_CMP_INIT) begin
			addr_a_q <= base_a_q;
			addr_b_q <= base_b_q;
			k_q      <= '0;
		end else if (state_q == S_BYTES) begin
			addr_a_q <= addr_a_q + 1'b1;
			addr_b_q <= addr_b_q + 1'b1;
			k_q      <= k_q + 1'b1;
		end
		if (state_q == S_LEN_AW) begin
			len_a_q <= len_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CAPTURE;
			fcnt_q         <= '0;
			pos_q          <= '0;
			ovl_q          <= 1'b0;
			frame_base_q   <= '0;
			idx_a_q        <= '0;
			idx_b_q        <= '0;
			base_a_q       <= '0;
			base_b_q       <= '0;
			rd_vld_s1      <= 1'b0;
			any_match_q    <= 1'b0;
			any_mismatch_q <= 1'b0;
			out_vld_q      <= 1'b0;
			out_cls_q      <= CLS_FIXED;
		end else begin
			rd_vld_s1 <= (state_q == S_BYTES);
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_CAPTURE: begin
					if (acc) begin
						if (s_tuser) begin
							// abort drops the whole session
							fcnt_q         <= '0;
							pos_q          <= '0;
							ovl_q          <= 1'b0;
							frame_base_q   <= '0;
							any_match_q    <= 1'b0;
							any_mismatch_q <= 1'b0;
						end else if (s_tlast) begin
							pos_q <= '0;
							ovl_q <= 1'b0;
							if (session_done) begin
								idx_a_q  <= '0;
								idx_b_q  <= FRM_W'(1);
								base_a_q <= '0;
								base_b_q <= STEP;
								state_q  <= S_LEN_A;
							end else if (frame_done) begin
								fcnt_q       <= fcnt_q + 1'b1;
								frame_base_q <= frame_base_q + STEP;
							end
						end else if (pos_full) begin
							ovl_q <= 1'b1;
						end else begin
							pos_q <= pos_inc;
						end
					end
				end
				S_LEN_A: begin
					state_q <= S_LEN_AW;
				end
				S_LEN_AW: begin
					state_q <= S_CMP_INIT;
				end
				S_LEN_B: begin
					state_q <= S_CMP_INIT;
				end
				S_CMP_INIT: begin
					if (len_rdata != len_a_q) begin
						// unequal lengths never match
						any_mismatch_q <= 1'b1;
						if (pairs_done) begin
							state_q <= S_EMIT;
						end else if (b_wrap) begin
							idx_a_q  <= idx_a_q + 1'b1;
							idx_b_q  <= idx_a_q + FRM_W'(2);
							base_a_q <= base_a_q + STEP;
							base_b_q <= base_a_q + STEP + STEP;
							state_q  <= S_LEN_A;
						end else begin
							idx_b_q  <= idx_b_q + 1'b1;
							base_b_q <= base_b_q + STEP;
							state_q  <= S_LEN_B;
						end
					end else begin
						state_q <= S_BYTES;
					end
				end
				S_BYTES: begin
					if (last_byte) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (pair_dist <= max_bit_diff_q) begin
						any_match_q <= 1'b1;
					end else begin
						any_mismatch_q <= 1'b1;
					end
					if (pairs_done) begin
						state_q <= S_EMIT;
					end else if (b_wrap) begin
						idx_a_q  <= idx_a_q + 1'b1;
						idx_b_q  <= idx_a_q + FRM_W'(2);
						base_a_q <= base_a_q + STEP;
						base_b_q <= base_a_q + STEP + STEP;
						state_q  <= S_LEN_A;
					end else begin
						idx_b_q  <= idx_b_q + 1'b1;
						base_b_q <= base_b_q + STEP;
						state_q  <= S_LEN_B;
					end
				end
				S_EMIT: begin
					// wait for the previous result to leave
					if (!out_vld_q) begin
						out_vld_q <= 1'b1;
						if (!any_mismatch_q) begin
							out_cls_q <= CLS_FIXED;
						end else if (!any_match_q) begin
							out_cls_q <= CLS_ROLLING;
						end else begin
							out_cls_q <= CLS_INCONSISTENT;
						end
						fcnt_q         <= '0;
						pos_q          <= '0;
						ovl_q          <= 1'b0;
						frame_base_q   <= '0;
						any_match_q    <= 1'b0;
						any_mismatch_q <= 1'b0;
						state_q        <= S_CAPTURE;
					end
				end
				default: begin
					state_q <= S_CAPTURE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, FRAMES_USED, out_cls_q};

	// byte data is only in flight right after a read was issued
	a_rd_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == S_BYTES))
		else $error("byte pair valid without a read");

	// byte reads never run past the length of the pair
	a_k_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BYTES) |-> (k_q < len_a_q))
		else $error("byte index beyond frame length");

	// a new result comes only from the emit step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

	// the class code is never the unused value
	a_cls_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'd3))
		else $error("invalid class code");

endmodule : capture_repeat_classifier_top
`default_nettype wire

// ===== hw/rtl/crcls_frame_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_frame_store
// byte store for all frames of a session, one write and two registered reads
// ----------------------------------------------------------------------------
module crcls_frame_store #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  wire                          clk,
	input  wire                          we,
	input  wire [ADDR_W-1:0]             waddr,
	input  wire [crcls_pkg::BYTE_W-1:0]  wdata,
	input  wire [ADDR_W-1:0]             raddr_a,
	input  wire [ADDR_W-1:0]             raddr_b,
	output logic [crcls_pkg::BYTE_W-1:0] rdata_a,
	output logic [crcls_pkg::BYTE_W-1:0] rdata_b
);
	import crcls_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule : crcls_frame_store
`default_nettype wire

// ===== hw/rtl/crcls_len_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_len_store
// length of each stored frame, one write and one registered read
// ----------------------------------------------------------------------------
module crcls_len_store #(
	parameter int DEPTH  = 8,
	parameter int IDX_W  = 3,
	parameter int LEN_W  = 7
) (
	input  wire              clk,
	input  wire              we,
	input  wire [IDX_W-1:0]  waddr,
	input  wire [LEN_W-1:0]  wdata,
	input  wire [IDX_W-1:0]  raddr,
	output logic [LEN_W-1:0] rdata
);
	logic [LEN_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : crcls_len_store
`default_nettype wire

// ===== hw/rtl/crcls_dist_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crcls_dist_acc
// saturating hamming distance of one frame pair, one byte pair per cycle while ctl.vld is set
// ----------------------------------------------------------------------------
module crcls_dist_acc (
	input  wire                          clk,
	input  wire crcls_pkg::acc_ctl_t     ctl,
	input  wire [crcls_pkg::BYTE_W-1:0]  byte_a,
	input  wire [crcls_pkg::BYTE_W-1:0]  byte_b,
	output logic [crcls_pkg::DIST_W-1:0] dist_q
);
	import crcls_pkg::*;

	logic [BYTE_W-1:0] diff;
	logic [3:0]        ones;
	logic [DIST_W:0]   sum;

	always_comb begin
		diff = byte_a ^ byte_b;
		ones = 4'd0;
		for (int i = 0; i < BYTE_W; i++) begin
			ones = ones + {3'd0, diff[i]};
		end
		sum = {1'b0, dist_q} + {{(DIST_W-3){1'b0}}, ones};
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			dist_q <= '0;
		end else if (ctl.vld) begin
			// clamp at the top of the range
			dist_q <= sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
		end
	end

endmodule : crcls_dist_acc
`default_nettype wire
